// ===== hdl/rct_pkg.sv =====
// rct_pkg: shared types and codes for the replication commit tracker.
// Transfer payload structs, event and view structs, action and register codes.
// No dependencies.
`timescale 1ns / 1ps

package rct_pkg;

   localparam int FIELD_W    = 32;
   localparam int FAIL_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PCOUNT_W   = 4;

   // action codes
   localparam logic [1:0] ACT_APPEND   = 2'd0;
   localparam logic [1:0] ACT_ACCEPT   = 2'd1;
   localparam logic [1:0] ACT_REJECT   = 2'd2;
   localparam logic [1:0] ACT_SNAPSHOT = 2'd3;

   // register index (word select bit of the byte address)
   localparam logic REG_PEER_COUNT = 1'b0;

   localparam logic [PCOUNT_W-1:0] PEER_COUNT_RESET = 4'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [2:0]         peer;
      logic [FIELD_W-1:0] snapshot_index;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] commit_point;
      logic [FIELD_W-1:0] log_end;
      logic [FIELD_W-1:0] peer_next;
      logic [FIELD_W-1:0] peer_match;
      logic [FAIL_W-1:0]  failure_total;
      logic               log_full;
   } rsp_type;

   // event handed from the input stage to the peer table
   typedef struct packed {
      logic       fire;
      logic [1:0] action;
      logic [2:0] peer;
   } event_type;

   // per-event view captured by the peer table (all but the commit point)
   typedef struct packed {
      logic [FIELD_W-1:0] log_end;
      logic [FIELD_W-1:0] peer_next;
      logic [FIELD_W-1:0] peer_match;
      logic [FAIL_W-1:0]  failure_total;
      logic               log_full;
   } view_type;

endpackage

// ===== hdl/rct_peer_table.sv =====
// rct_peer_table: per-follower next/match tables, last log index, reject count.
// Applies one event per fire and registers the resulting view.
// Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_peer_table #(
   parameter int MAX_PEERS  = 8,
   parameter int INDEX_BITS = 32,
   parameter int CNT_W      = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rct_pkg::event_type                     ev,
   input  logic [INDEX_BITS-1:0]                  snap_index,
   input  logic [CNT_W-1:0]                       eff_count,
   output logic [MAX_PEERS-1:0][INDEX_BITS-1:0]   match_table,
   output logic [INDEX_BITS-1:0]                  last_entry,
   output rct_pkg::view_type                      view
);
   import rct_pkg::*;

   logic [MAX_PEERS-1:0][INDEX_BITS-1:0] next_ff, next_in;
   logic [MAX_PEERS-1:0][INDEX_BITS-1:0] match_ff, match_in;
   logic [INDEX_BITS-1:0]                last_ff, last_in;
   logic [FAIL_W-1:0]                    reject_ff, reject_in;
   view_type                             view_ff, view_in;
   logic                                 live;
   logic                                 full;
   logic [INDEX_BITS-1:0]                rd_next, rd_match;

   function automatic logic [INDEX_BITS-1:0] bump_sat(input logic [INDEX_BITS-1:0] v);
      return (&v) ? v : v + INDEX_BITS'(1);
   endfunction

   always_comb begin
      next_in   = next_ff;
      match_in  = match_ff;
      last_in   = last_ff;
      reject_in = reject_ff;
      full      = 1'b0;
      live      = (32'(ev.peer) < 32'(eff_count));

      if (ev.fire && ev.action == ACT_APPEND) begin
         if (&last_ff) full = 1'b1;
         else          last_in = last_ff + INDEX_BITS'(1);
      end
      if (ev.fire && live && ev.action == ACT_REJECT) begin
         reject_in = reject_ff + FAIL_W'(1);
      end

      for (int k = 0; k < MAX_PEERS; k++) begin
         if (ev.fire && live && 32'(ev.peer) == k) begin
            case (ev.action)
               ACT_ACCEPT: begin
                  match_in[k] = next_ff[k];
                  next_in[k]  = bump_sat(next_ff[k]);
               end
               ACT_REJECT: begin
                  if (next_ff[k] > INDEX_BITS'(1)) next_in[k] = next_ff[k] - INDEX_BITS'(1);
               end
               ACT_SNAPSHOT: begin
                  match_in[k] = snap_index;
                  next_in[k]  = bump_sat(snap_index);
               end
               default: begin
               end
            endcase
         end
      end

      // peers beyond the table read as reset values
      rd_next  = INDEX_BITS'(1);
      rd_match = '0;
      for (int k = 0; k < MAX_PEERS; k++) begin
         if (32'(ev.peer) == k) begin
            rd_next  = next_in[k];
            rd_match = match_in[k];
         end
      end

      view_in.log_end       = FIELD_W'(last_in);
      view_in.peer_next     = FIELD_W'(rd_next);
      view_in.peer_match    = FIELD_W'(rd_match);
      view_in.failure_total = reject_in;
      view_in.log_full      = full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PEERS; k++) begin
            next_ff[k]  <= INDEX_BITS'(1);
            match_ff[k] <= '0;
         end
         last_ff   <= '0;
         reject_ff <= '0;
      end else begin
         next_ff   <= next_in;
         match_ff  <= match_in;
         last_ff   <= last_in;
         reject_ff <= reject_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev.fire) begin
         view_ff <= view_in;
      end
   end

   assign match_table = match_ff;
   assign last_entry  = last_ff;
   assign view        = view_ff;

endmodule

// ===== hdl/rct_commit_rank.sv =====
// rct_commit_rank: commit index register and the rank compare over the match table.
// Picks the majority-replicated index and raises the commit index to it.
// Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_commit_rank #(
   parameter int MAX_PEERS  = 8,
   parameter int INDEX_BITS = 32,
   parameter int CNT_W      = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  logic [MAX_PEERS-1:0][INDEX_BITS-1:0] match_table,
   input  logic [INDEX_BITS-1:0]                last_entry,
   input  logic [CNT_W-1:0]                     eff_count,
   output logic [INDEX_BITS-1:0]                commit_next
);
   import rct_pkg::*;

   logic [INDEX_BITS-1:0]                committed_ff, committed_in;
   logic [MAX_PEERS-1:0][MAX_PEERS-1:0]  ge;       // ge[i][j]: match[j] >= match[i]
   logic [CNT_W-1:0]                     ge_cnt [MAX_PEERS];
   logic [CNT_W-1:0]                     gt_cnt [MAX_PEERS];
   logic [MAX_PEERS-1:0]                 sel;
   logic [CNT_W-1:0]                     need;
   logic [INDEX_BITS-1:0]                best;
   logic [INDEX_BITS-1:0]                capped;

   always_comb begin
      need = eff_count >> 1;
      for (int i = 0; i < MAX_PEERS; i++) begin
         for (int j = 0; j < MAX_PEERS; j++) begin
            ge[i][j] = (match_table[j] >= match_table[i]);
         end
      end
      // sel marks entries holding the need-th largest live value; ties
      // share that value, so an OR mux is enough
      best = '0;
      for (int i = 0; i < MAX_PEERS; i++) begin
         ge_cnt[i] = '0;
         gt_cnt[i] = '0;
         for (int j = 0; j < MAX_PEERS; j++) begin
            if (j < int'(eff_count)) begin
               if (ge[i][j])  ge_cnt[i] = ge_cnt[i] + CNT_W'(1);
               if (!ge[j][i]) gt_cnt[i] = gt_cnt[i] + CNT_W'(1);
            end
         end
         sel[i] = (i < int'(eff_count)) && (ge_cnt[i] >= need) && (gt_cnt[i] < need);
         if (sel[i]) best = best | match_table[i];
      end
      if (need == '0) best = last_entry;

      capped       = (best > last_entry) ? last_entry : best;
      committed_in = (capped > committed_ff) ? capped : committed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= '0;
      end else if (fire) begin
         committed_ff <= committed_in;
      end
   end

   assign commit_next = committed_in;

endmodule

// ===== hdl/replication_commit_tracker_unit.sv =====
// replication_commit_tracker_unit: leader-side replication bookkeeping, top level.
// Instantiates rct_peer_table and rct_commit_rank; uses rct_pkg.
`timescale 1ns / 1ps

// Takes one replication event per cycle (local append, follower accept,
// follower reject, follower snapshot) and returns one result per event: the
// commit index, last log index, the named follower's next and match index,
// the reject count and the log-full flag, all as they stand after that event.
// Events pass the input register, table update and commit stage in turn. The
// cycle is set by the commit stage, which ranks all live match entries
// against each other in parallel. A stall on the result side freezes the
// whole pipe and is passed back to req_stall in the same cycle. peer_count
// is written over the CSR port at byte address 0; the user must do so only
// while no event is in flight; the block does not enforce it. Values above
// MAX_PEERS act as MAX_PEERS. State comes out of reset ready, with no sweep.

module replication_commit_tracker_unit #(
   parameter int MAX_PEERS  = 8,
   parameter int INDEX_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // event channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rct_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rct_pkg::rsp_type                  rsp_data,
   // CSR port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rct_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rct_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rct_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import rct_pkg::*;

   localparam int CNT_W = $clog2(MAX_PEERS + 1);

   // pipe advances unless a finished result is held off
   logic                                 advance;
   logic                                 s1_valid_ff, s1_valid_in;
   req_type                              s1_data_ff;
   logic                                 s2_valid_ff, s2_valid_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   rsp_type                              rsp_data_ff, rsp_data_in;
   logic [PCOUNT_W-1:0]                  peer_count_ff, peer_count_in;
   logic [CNT_W-1:0]                     eff_count;
   event_type                            ev;
   view_type                             view;
   logic [MAX_PEERS-1:0][INDEX_BITS-1:0] match_table;
   logic [INDEX_BITS-1:0]                last_entry;
   logic [INDEX_BITS-1:0]                commit_next;
   logic                                 csr_write;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // --- CSR ---
   // word select is the top address bit; byte offset bits are ignored
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_PEER_COUNT) ?
                       CSR_DATA_W'(peer_count_ff) : '0;

   always_comb begin
      peer_count_in = peer_count_ff;
      if (csr_write && csr_paddr[CSR_ADDR_W-1] == REG_PEER_COUNT) begin
         peer_count_in = csr_pwdata[PCOUNT_W-1:0];
      end
   end

   // live follower count, clamped to the table
   assign eff_count = ({1'b0, peer_count_ff} > (PCOUNT_W+1)'(MAX_PEERS)) ?
                      CNT_W'(MAX_PEERS) : CNT_W'(peer_count_ff);

   // --- pipeline control ---
   assign s1_valid_in  = advance ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = advance ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = advance ? s2_valid_ff : rsp_valid_ff;

   assign ev.fire   = advance && s1_valid_ff;
   assign ev.action = s1_data_ff.action;
   assign ev.peer   = s1_data_ff.peer;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         peer_count_ff <= PEER_COUNT_RESET;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         peer_count_ff <= peer_count_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         s1_data_ff <= req_data;
      end
   end

   // stage 2: table update
   rct_peer_table #(
      .MAX_PEERS  (MAX_PEERS),
      .INDEX_BITS (INDEX_BITS),
      .CNT_W      (CNT_W)
   ) u_peer_table (
      .clock       (clock),
      .reset       (reset),
      .ev          (ev),
      .snap_index  (INDEX_BITS'(s1_data_ff.snapshot_index)),
      .eff_count   (eff_count),
      .match_table (match_table),
      .last_entry  (last_entry),
      .view        (view)
   );

   // stage 3: commit rank over the updated tables
   rct_commit_rank #(
      .MAX_PEERS  (MAX_PEERS),
      .INDEX_BITS (INDEX_BITS),
      .CNT_W      (CNT_W)
   ) u_commit_rank (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance && s2_valid_ff),
      .match_table (match_table),
      .last_entry  (last_entry),
      .eff_count   (eff_count),
      .commit_next (commit_next)
   );

   always_comb begin
      rsp_data_in.commit_point  = FIELD_W'(commit_next);
      rsp_data_in.log_end       = view.log_end;
      rsp_data_in.peer_next     = view.peer_next;
      rsp_data_in.peer_match    = view.peer_match;
      rsp_data_in.failure_total = view.failure_total;
      rsp_data_in.log_full      = view.log_full;
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/rct_checker.sv =====
// rct_checker: port-level assertions for replication_commit_tracker_unit.
// Bound to the top level below; uses rct_pkg.
`timescale 1ns / 1ps

module rct_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rct_pkg::rsp_type rsp_data
);
   import rct_pkg::*;

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // backpressure only comes from a held result
   a_stall_source: assert property (@(posedge clock)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no result pending");

   // reset empties the pipe
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // with the pipe free, a stall cannot appear next cycle unless a result was due
   a_no_spurious_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_valid ##1 !req_valid |-> !req_stall || rsp_valid)
      else $error("stall without a result");

endmodule

bind replication_commit_tracker_unit rct_checker u_rct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== test/tb_replication_commit_tracker_unit.sv =====
// tb_replication_commit_tracker_unit: self-checking bench for the commit tracker.
// Drives events, models the follower tables and commit rule, checks every result.
// Depends on rct_pkg and replication_commit_tracker_unit.
`timescale 1ns / 1ps

module tb_replication_commit_tracker_unit;
   import rct_pkg::*;

   localparam int TABLE_DEPTH = 8;
   localparam int QUIET_LIMIT = 2000;  // cycles without any transfer before giving up
   localparam int LONG_HOLD   = 120;   // one long result-side hold to back the pipe up
   localparam int HOLD_AFTER  = 400;   // events sent before the long hold starts
   localparam int DRAIN_WAIT  = 8;     // pipe is three deep, leave some margin
   localparam logic [CSR_ADDR_W-1:0] PEER_COUNT_ADDR = {REG_PEER_COUNT, 2'b00};
   localparam logic [FIELD_W-1:0] INDEX_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // --------------------------------------------------------------------
   // Model state: follower tables, log tail, commit point, reject counter
   // --------------------------------------------------------------------
   logic [FIELD_W-1:0]  next_send  [TABLE_DEPTH];
   logic [FIELD_W-1:0]  acked_upto [TABLE_DEPTH];
   logic [FIELD_W-1:0]  log_tail;
   logic [FIELD_W-1:0]  commit_idx;
   logic [FAIL_W-1:0]   reject_total;
   logic [PCOUNT_W-1:0] peer_count_cfg;

   req_type event_queue[$];      // events waiting for the driver
   rsp_type commit_reports[$];   // expected results, oldest first

   int          error_count = 0;
   int          sent_count  = 0;
   int          send_gap    = 0;
   int          stall_left  = 0;
   int          hold_left   = 0;
   int          quiet_cycles = 0;
   logic        idle_on     = 1'b1;
   logic        in_hold     = 1'b0;
   logic        hold_done   = 1'b0;
   int unsigned planned_tail = 0;  // rough log tail seen by the generator

   replication_commit_tracker_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Followers that take part; a count above the table acts as the full table.
   function automatic int live_count();
      return (peer_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(peer_count_cfg);
   endfunction

   function automatic logic [FIELD_W-1:0] bump_index(logic [FIELD_W-1:0] v);
      return (v == INDEX_MAX) ? INDEX_MAX : v + 1'b1;
   endfunction

   // Applies one event to the model and returns the result it should produce.
   function automatic rsp_type apply_event(req_type ev);
      rsp_type            r;
      logic               live;
      logic               full;
      int                 n;
      int                 quorum;
      int                 votes;
      logic               found;
      logic [FIELD_W-1:0] best;
      n     = live_count();
      live  = int'(ev.peer) < n;
      full  = 1'b0;
      case (ev.action)
         ACT_APPEND: begin
            if (log_tail == INDEX_MAX) full = 1'b1;
            else log_tail = log_tail + 1'b1;
         end
         ACT_ACCEPT: begin
            if (live) begin
               acked_upto[ev.peer] = next_send[ev.peer];
               next_send[ev.peer]  = bump_index(next_send[ev.peer]);
            end
         end
         ACT_REJECT: begin
            if (live) begin
               reject_total = reject_total + 1'b1;
               if (next_send[ev.peer] > 1) next_send[ev.peer] = next_send[ev.peer] - 1'b1;
            end
         end
         ACT_SNAPSHOT: begin
            if (live) begin
               acked_upto[ev.peer] = ev.snapshot_index;
               next_send[ev.peer]  = bump_index(ev.snapshot_index);
            end
         end
      endcase

      // Commit rule: the leader counts as one vote, so a match value commits once
      // at least n/2 live followers have reached it.
      quorum = n / 2;
      found  = 1'b0;
      best   = '0;
      if (quorum == 0) begin
         best  = log_tail;
         found = 1'b1;
      end else begin
         for (int i = 0; i < n; i++) begin
            votes = 0;
            for (int j = 0; j < n; j++)
               if (acked_upto[j] >= acked_upto[i]) votes++;
            if (votes >= quorum && (!found || acked_upto[i] > best)) begin
               best  = acked_upto[i];
               found = 1'b1;
            end
         end
      end
      if (found) begin
         if (best > log_tail) best = log_tail;
         if (best > commit_idx) commit_idx = best;
      end

      r.commit_point  = commit_idx;
      r.log_end       = log_tail;
      r.peer_next     = next_send[ev.peer];
      r.peer_match    = acked_upto[ev.peer];
      r.failure_total = reject_total;
      r.log_full      = full;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // --------------------------------------------------------------------
   // Driver: presents queued events, predicts each one on its transfer.
   // Valid is only dropped after a transfer, never while stalled.
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            commit_reports.push_back(apply_event(req_data));
            sent_count <= sent_count + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (event_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if (idle_on && !in_hold && $urandom_range(0, 7) == 0) begin
               // idle burst: valid low now and while send_gap counts down
               send_gap = $urandom_range(0, 12);
               req_valid <= 1'b0;
            end else begin
               req_data  <= event_queue.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // Result-side stall: random bursts, plus one long hold part way through
   // so the pipe fills and the block has to stall its input.
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         in_hold   <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else if (!hold_done && sent_count >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         in_hold   <= 1'b1;
         hold_left  = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         in_hold   <= 1'b0;
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         in_hold   <= 1'b0;
         stall_left = $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end else begin
         in_hold   <= 1'b0;
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: every result transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (commit_reports.size() == 0) begin
            $error("result with no event outstanding: commit_point %0d",
                   rsp_data.commit_point);
            error_count++;
         end else begin
            want = commit_reports.pop_front();
            check_field("commit_point", want.commit_point, rsp_data.commit_point);
            check_field("log_end", want.log_end, rsp_data.log_end);
            check_field("peer_next", want.peer_next, rsp_data.peer_next);
            check_field("peer_match", want.peer_match, rsp_data.peer_match);
            check_field("failure_total", want.failure_total, rsp_data.failure_total);
            check_field("log_full", 32'(want.log_full), 32'(rsp_data.log_full));
         end
      end
   end

   // Watchdog: a long run of cycles with no transfer on either channel is a hang.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void push_event(logic [1:0] action, logic [2:0] peer,
                                      logic [FIELD_W-1:0] snap);
      req_type ev;
      ev.action         = action;
      ev.peer           = peer;
      ev.snapshot_index = snap;
      event_queue.push_back(ev);
      if (action == ACT_APPEND) planned_tail++;
   endfunction

   // Mostly well-formed traffic: appends followed by acks from live followers,
   // snapshots near the log tail; the rest rejects, dead peers and wild indexes.
   task automatic queue_random_events(int count);
      int          pick;
      int          near;
      logic [1:0]  action;
      logic [2:0]  peer;
      logic [31:0] snap;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) action = ACT_APPEND;
         else if (pick < 62) action = ACT_ACCEPT;
         else if (pick < 78) action = ACT_REJECT;
         else action = ACT_SNAPSHOT;
         if (live_count() > 0 && $urandom_range(0, 99) < 85)
            peer = 3'($urandom_range(0, live_count() - 1));
         else
            peer = 3'($urandom_range(0, 7));
         snap = $urandom();
         if (action == ACT_SNAPSHOT) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               near = int'(planned_tail) - int'($urandom_range(0, 6)) + int'($urandom_range(0, 2));
               snap = (near < 0) ? 32'd0 : 32'(near);
            end else if (pick == 9) begin
               snap = $urandom_range(0, 1) ? INDEX_MAX : '0;
            end
         end
         push_event(action, peer, snap);
      end
   endtask

   // Register write (setup then access), then read back over the same port.
   task automatic write_peer_count(logic [PCOUNT_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PEER_COUNT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);  // write lands on this edge
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);  // read access completes on this edge
      if (csr_prdata[PCOUNT_W-1:0] !== value) begin
         $error("peer_count readback: expected %0d, actual %0d", value,
                csr_prdata[PCOUNT_W-1:0]);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      peer_count_cfg = value;
   endtask

   // Wait until every queued event is sent and every result has come back.
   task automatic drain();
      @(negedge clock);
      while (event_queue.size() != 0 || req_valid || commit_reports.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // --------------------------------------------------------------------
   // Sequence: reset, directed cases at the reset peer count of two, then
   // random phases over a spread of peer counts, the last one without idling.
   // --------------------------------------------------------------------
   initial begin
      logic [PCOUNT_W-1:0] count_plan [9];
      count_plan = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd3, 4'd9, 4'd5, 4'd2, 4'd4};

      for (int i = 0; i < TABLE_DEPTH; i++) begin
         next_send[i]  = 1;
         acked_upto[i] = 0;
      end
      log_tail       = '0;
      commit_idx     = '0;
      reject_total   = '0;
      peer_count_cfg = PEER_COUNT_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_event(ACT_APPEND, 3'd0, $urandom());
      push_event(ACT_APPEND, 3'd7, $urandom());        // peer ignored on append
      push_event(ACT_ACCEPT, 3'd0, $urandom());        // one follower is a quorum of two
      push_event(ACT_ACCEPT, 3'd1, $urandom());
      push_event(ACT_ACCEPT, 3'd0, $urandom());
      push_event(ACT_REJECT, 3'd1, $urandom());        // next drops to the floor
      push_event(ACT_REJECT, 3'd1, $urandom());        // and stays at one
      push_event(ACT_ACCEPT, 3'd5, $urandom());        // peers beyond the live set
      push_event(ACT_REJECT, 3'd7, $urandom());
      push_event(ACT_SNAPSHOT, 3'd2, INDEX_MAX);
      push_event(ACT_SNAPSHOT, 3'd1, 32'd0);
      push_event(ACT_SNAPSHOT, 3'd1, INDEX_MAX);       // next saturates
      push_event(ACT_ACCEPT, 3'd1, $urandom());        // accept at saturated next
      push_event(ACT_REJECT, 3'd1, 32'h0);
      push_event(ACT_SNAPSHOT, 3'd0, 32'h5555_5555);   // match far beyond the log
      push_event(ACT_SNAPSHOT, 3'd0, 32'hAAAA_AAAA);
      push_event(ACT_APPEND, 3'd4, 32'hFFFF_FFFF);
      push_event(ACT_APPEND, 3'd6, 32'h0);
      push_event(ACT_SNAPSHOT, 3'd0, 32'd2);
      push_event(ACT_ACCEPT, 3'd0, $urandom());
      push_event(ACT_APPEND, 3'd3, $urandom());
      drain();

      foreach (count_plan[p]) begin
         if (p == 8) idle_on <= 1'b0;
         write_peer_count(count_plan[p]);
         @(negedge clock);
         queue_random_events(92);
         drain();
      end

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
